>>> rtl/ppfp_pkg.sv
`timescale 1ns / 1ps
package ppfp_pkg;

   localparam int PAIRS_DEF      = 8;
   localparam int RING_BYTES_DEF = 1024;

   typedef enum logic [2:0] {
      KIND_ALLOC       = 3'd0,
      KIND_OPEN_SLAVE  = 3'd1,
      KIND_REL_MASTER  = 3'd2,
      KIND_REL_SLAVE   = 3'd3,
      KIND_M_WRITE     = 3'd4,
      KIND_M_READ      = 3'd5,
      KIND_S_WRITE     = 3'd6,
      KIND_S_READ      = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      STS_OK      = 3'd0,
      STS_BAD     = 3'd1,
      STS_BLOCK   = 3'd2,
      STS_CLOSED  = 3'd3,
      STS_NO_FREE = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_READ,
      FSM_DONE
   } state_type;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  pair_index;
      logic [7:0]  data_byte;
      logic        end_of_request;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  read_byte;
      logic [2:0]  granted_pair;
      logic        request_done;
      logic [10:0] fill_level;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic capture;
   } cmd_type;

   typedef struct packed {
      logic rd_pending;
   } dp_status_type;

endpackage

>>> rtl/pty_pair_fifo_pool.sv
`timescale 1ns / 1ps
// channel   dir  handshake              payload
// req_      in   req_valid / req_stall  ppfp_pkg::req_type
// rsp_      out  rsp_valid / rsp_stall  ppfp_pkg::rsp_type
//
// One item at a time: accept, execute, then the response is held. A
// successful read passes a capture state after execute, which waits on the
// registered read port of the ring store, before the response is valid.
// A stalled response holds the block; no new transfer is taken until it goes.
// Synchronous reset clears pair flags and ring pointers; the store is not swept.
module pty_pair_fifo_pool #(
   parameter int PAIRS      = ppfp_pkg::PAIRS_DEF,
   parameter int RING_BYTES = ppfp_pkg::RING_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ppfp_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ppfp_pkg::rsp_type rsp_payload
);

   ppfp_pkg::cmd_type       cmd;
   ppfp_pkg::dp_status_type dp_sts;

   ppfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_sts    (dp_sts),
      .cmd       (cmd)
   );

   ppfp_dp #(
      .PAIRS      (PAIRS),
      .RING_BYTES (RING_BYTES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .dp_sts      (dp_sts),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> rtl/ppfp_ram.sv
`timescale 1ns / 1ps
module ppfp_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16384,
   parameter int ADDR_W = 14
) (
   input  logic              clock,
   input  logic              en,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/ppfp_ctrl.sv
`timescale 1ns / 1ps
module ppfp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  ppfp_pkg::dp_status_type dp_sts,
   output ppfp_pkg::cmd_type      cmd
);

   ppfp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ppfp_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ppfp_pkg::FSM_IDLE: begin
            if (req_valid) state_in = ppfp_pkg::FSM_EXEC;
         end
         ppfp_pkg::FSM_EXEC: begin
            state_in = dp_sts.rd_pending ? ppfp_pkg::FSM_READ : ppfp_pkg::FSM_DONE;
         end
         ppfp_pkg::FSM_READ: begin
            state_in = ppfp_pkg::FSM_DONE;
         end
         ppfp_pkg::FSM_DONE: begin
            if (!rsp_stall) state_in = ppfp_pkg::FSM_IDLE;
         end
         default: state_in = ppfp_pkg::FSM_IDLE;
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      cmd.load    = 1'b0;
      cmd.exec    = 1'b0;
      cmd.capture = 1'b0;
      unique case (state_ff)
         ppfp_pkg::FSM_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ppfp_pkg::FSM_EXEC: cmd.exec    = 1'b1;
         ppfp_pkg::FSM_READ: cmd.capture = 1'b1;
         ppfp_pkg::FSM_DONE: rsp_valid   = 1'b1;
         default: req_stall = 1'b1;
      endcase
   end

endmodule

>>> rtl/ppfp_dp.sv
`timescale 1ns / 1ps
module ppfp_dp #(
   parameter int PAIRS      = ppfp_pkg::PAIRS_DEF,
   parameter int RING_BYTES = ppfp_pkg::RING_BYTES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ppfp_pkg::req_type       req_payload,
   input  ppfp_pkg::cmd_type       cmd,
   output ppfp_pkg::dp_status_type dp_sts,
   output ppfp_pkg::rsp_type       rsp_payload
);

   localparam int PAIR_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;
   localparam int RINGS  = 2 * PAIRS;
   localparam int RING_W = PAIR_W + 1;
   localparam int PTR_W  = $clog2(RING_BYTES);
   localparam int CNT_W  = $clog2(RING_BYTES + 1);
   localparam int ADDR_W = RING_W + PTR_W;
   localparam int DEPTH  = RINGS * (2 ** PTR_W);

   ppfp_pkg::req_type req_ff;
   ppfp_pkg::rsp_type rsp_ff, rsp_in;

   logic [PAIRS-1:0] busy_ff, busy_in;
   logic [PAIRS-1:0] mopen_ff, mopen_in;
   logic [PAIRS-1:0] sopen_ff, sopen_in;
   logic [RINGS-1:0] closed_ff, closed_in;
   logic [PTR_W-1:0] wp_ff [RINGS];
   logic [PTR_W-1:0] wp_in [RINGS];
   logic [PTR_W-1:0] rp_ff [RINGS];
   logic [PTR_W-1:0] rp_in [RINGS];
   logic [CNT_W-1:0] cnt_ff [RINGS];
   logic [CNT_W-1:0] cnt_in [RINGS];

   logic              pair_ok, busy, dir_up, is_write, is_read;
   logic [PAIR_W-1:0] pidx, free_idx;
   logic              free_found;
   logic [RING_W-1:0] ring;
   logic [PTR_W-1:0]  wp_cur, rp_cur, wp_adv, rp_adv;
   logic [CNT_W-1:0]  cnt_cur;
   logic              full, empty, rd_ok;
   logic              ram_en, ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [7:0]        ram_rdata;

   assign pair_ok  = {1'b0, req_ff.pair_index} < 5'(PAIRS);
   assign pidx     = req_ff.pair_index[PAIR_W-1:0];
   assign busy     = pair_ok && busy_ff[pidx];
   assign dir_up   = (req_ff.kind == ppfp_pkg::KIND_M_READ) ||
                     (req_ff.kind == ppfp_pkg::KIND_S_WRITE);
   assign is_write = (req_ff.kind == ppfp_pkg::KIND_M_WRITE) ||
                     (req_ff.kind == ppfp_pkg::KIND_S_WRITE);
   assign is_read  = (req_ff.kind == ppfp_pkg::KIND_M_READ) ||
                     (req_ff.kind == ppfp_pkg::KIND_S_READ);
   assign ring     = {pidx, dir_up};
   assign wp_cur   = wp_ff[ring];
   assign rp_cur   = rp_ff[ring];
   assign cnt_cur  = cnt_ff[ring];
   assign wp_adv   = (wp_cur == PTR_W'(RING_BYTES - 1)) ? '0 : wp_cur + 1'b1;
   assign rp_adv   = (rp_cur == PTR_W'(RING_BYTES - 1)) ? '0 : rp_cur + 1'b1;
   assign full     = cnt_cur >= CNT_W'(RING_BYTES);
   assign empty    = cnt_cur == '0;
   assign rd_ok    = busy && is_read && !empty;

   assign dp_sts.rd_pending = rd_ok;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = PAIRS - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_found = 1'b1;
            free_idx   = PAIR_W'(i);
         end
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      mopen_in  = mopen_ff;
      sopen_in  = sopen_ff;
      closed_in = closed_ff;
      wp_in     = wp_ff;
      rp_in     = rp_ff;
      cnt_in    = cnt_ff;
      ram_en    = 1'b0;
      ram_we    = 1'b0;
      ram_addr  = {ring, is_write ? wp_cur : rp_cur};

      rsp_in.status       = ppfp_pkg::STS_OK;
      rsp_in.read_byte    = '0;
      rsp_in.granted_pair = '0;
      rsp_in.request_done = req_ff.end_of_request;
      rsp_in.fill_level   = '0;

      if (req_ff.kind == ppfp_pkg::KIND_ALLOC) begin
         if (free_found) begin
            busy_in[free_idx]  = 1'b1;
            mopen_in[free_idx] = 1'b1;
            sopen_in[free_idx] = 1'b0;
            for (int d = 0; d < 2; d++) begin
               wp_in[{free_idx, 1'(d)}]     = '0;
               rp_in[{free_idx, 1'(d)}]     = '0;
               cnt_in[{free_idx, 1'(d)}]    = '0;
               closed_in[{free_idx, 1'(d)}] = 1'b0;
            end
            rsp_in.granted_pair = 3'(free_idx);
         end else begin
            rsp_in.status = ppfp_pkg::STS_NO_FREE;
         end
      end else if (!busy) begin
         rsp_in.status = ppfp_pkg::STS_BAD;
      end else begin
         case (req_ff.kind) inside
            ppfp_pkg::KIND_OPEN_SLAVE: begin
               if (!mopen_ff[pidx] || sopen_ff[pidx]) begin
                  rsp_in.status = ppfp_pkg::STS_BAD;
               end else begin
                  sopen_in[pidx] = 1'b1;
               end
            end
            ppfp_pkg::KIND_REL_MASTER, ppfp_pkg::KIND_REL_SLAVE: begin
               if (req_ff.kind == ppfp_pkg::KIND_REL_MASTER) begin
                  mopen_in[pidx] = 1'b0;
               end else begin
                  sopen_in[pidx] = 1'b0;
               end
               closed_in[{pidx, 1'b0}] = 1'b1;
               closed_in[{pidx, 1'b1}] = 1'b1;
               if (!mopen_in[pidx] && !sopen_in[pidx]) busy_in[pidx] = 1'b0;
            end
            default: begin
               rsp_in.fill_level = 11'(cnt_cur);
               if (is_write) begin
                  if (full) begin
                     rsp_in.status = closed_ff[ring] ? ppfp_pkg::STS_CLOSED
                                                     : ppfp_pkg::STS_BLOCK;
                  end else begin
                     ram_en            = 1'b1;
                     ram_we            = 1'b1;
                     wp_in[ring]       = wp_adv;
                     cnt_in[ring]      = cnt_cur + 1'b1;
                     rsp_in.fill_level = 11'(cnt_cur + 1'b1);
                  end
               end else begin
                  if (empty) begin
                     rsp_in.status = closed_ff[ring] ? ppfp_pkg::STS_CLOSED
                                                     : ppfp_pkg::STS_BLOCK;
                  end else begin
                     ram_en            = 1'b1;
                     rp_in[ring]       = rp_adv;
                     cnt_in[ring]      = cnt_cur - 1'b1;
                     rsp_in.fill_level = 11'(cnt_cur - 1'b1);
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= '0;
         mopen_ff  <= '0;
         sopen_ff  <= '0;
         closed_ff <= '0;
         for (int r = 0; r < RINGS; r++) begin
            wp_ff[r]  <= '0;
            rp_ff[r]  <= '0;
            cnt_ff[r] <= '0;
         end
      end else if (cmd.exec) begin
         busy_ff   <= busy_in;
         mopen_ff  <= mopen_in;
         sopen_ff  <= sopen_in;
         closed_ff <= closed_in;
         wp_ff     <= wp_in;
         rp_ff     <= rp_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_payload;
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end else if (cmd.capture) begin
         rsp_ff.read_byte <= ram_rdata;
      end
   end

   assign rsp_payload = rsp_ff;

   ppfp_ram #(
      .WIDTH  (8),
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock (clock),
      .en    (ram_en && cmd.exec),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_ff.data_byte),
      .rdata (ram_rdata)
   );

endmodule

>>> rtl/ppfp_checker.sv
`timescale 1ns / 1ps
module ppfp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input ppfp_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input ppfp_pkg::rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("response dropped or changed while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transfer taken while one is in flight");

   a_no_take_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a response waits");

   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != ppfp_pkg::STS_OK
      |-> rsp_payload.read_byte == '0 && rsp_payload.granted_pair == '0)
      else $error("failed operation carries data");

   a_bad_no_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == ppfp_pkg::STS_BAD ||
                    rsp_payload.status == ppfp_pkg::STS_NO_FREE)
      |-> rsp_payload.fill_level == '0)
      else $error("rejected operation reports a fill level");

endmodule

bind pty_pair_fifo_pool ppfp_checker u_ppfp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
